// File: rtl/pps_pkg.sv
// phong point shader package: widths, register codes and the log2/exp2 tables
// no dependencies; used by pps_power and phong_point_shader_unit
package pps_pkg;

    localparam int LOG_TABLE_BITS = 10;
    localparam int EXP_TABLE_BITS = 10;
    localparam int LOG_SIZE = 1 << LOG_TABLE_BITS;
    localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;

    localparam int COLOR_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_STG = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALBEDO   = 3'd0,
        REG_SPECULAR = 3'd1,
        REG_LIGHT    = 3'd2,
        REG_KD       = 3'd3,
        REG_KS       = 3'd4,
        REG_SHINE    = 3'd5
    } t_cfg_reg;

    typedef logic [16:0] t_log_tab [LOG_SIZE];
    typedef logic [15:0] t_exp_tab [EXP_SIZE];

    function automatic longint unsigned f_isqrt64(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/size) in Q0.16 by repeated squaring
    function automatic t_log_tab f_log_tab();
        t_log_tab        tab;
        longint unsigned x;
        longint unsigned acc;
        for (int i = 0; i < LOG_SIZE; i++) begin
            x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            acc = 0;
            for (int k = 0; k < 17; k++) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    acc = acc | (64'd1 << (16 - k));
                end
            end
            tab[i] = 17'((acc + 64'd1) >> 1);
        end
        return tab;
    endfunction

    // 2^(-j/size) in Q1.15 from products of repeated square roots
    function automatic t_exp_tab f_exp_tab();
        t_exp_tab        tab;
        longint unsigned roots [EXP_TABLE_BITS+1];
        longint unsigned acc;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= EXP_TABLE_BITS; k++) roots[k] = f_isqrt64(roots[k-1] << 32);
        for (int i = 0; i < EXP_SIZE; i++) begin
            acc = 64'd1 << 32;
            for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
                if (((i >> (EXP_TABLE_BITS - k)) & 1) != 0) acc = (acc * roots[k]) >> 32;
            end
            tab[i] = 16'((acc + (64'd1 << 16)) >> 17);
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = f_log_tab();
    localparam t_exp_tab EXP_TAB = f_exp_tab();

endpackage

// File: rtl/pps_power.sv
// specular power c^(shine/2048) as exp2(e*log2(c)), four register stages
// depends on pps_pkg for the log and exp tables
module pps_power import pps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_cos,
    input  logic [15:0] i_shine,
    output logic [15:0] o_pow
);

    // stage a: leading one and table index
    logic [3:0]                w_p;
    logic [15:0]               w_m;
    logic [LOG_TABLE_BITS-1:0] r_a_idx;
    logic [3:0]                r_a_sh;
    logic                      r_a_zero, r_a_one;
    // stage b: negative log
    logic [19:0]               r_b_negl;
    logic                      r_b_zero, r_b_one;
    // stage c: scaled by exponent
    logic [35:0]               w_t;
    logic [24:0]               r_c_t;
    logic                      r_c_zero, r_c_one;
    // stage d: exp lookup
    logic [8:0]                w_n;
    logic [EXP_TABLE_BITS-1:0] w_j;
    logic [15:0]               n_pow;
    logic [15:0]               r_pow;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < 15; i++) begin
            if (i_cos[i]) w_p = 4'(i);
        end
        w_m = i_cos << (4'd15 - w_p);
    end

    assign w_t = 36'(i_shine) * 36'(r_b_negl);
    assign w_n = r_c_t[24:16];
    assign w_j = r_c_t[15 -: EXP_TABLE_BITS];

    always_comb begin
        if (r_c_zero) begin
            n_pow = '0;
        end else if (r_c_one) begin
            n_pow = 16'd32768;
        end else if (w_n >= 9'd16) begin
            n_pow = '0;
        end else begin
            n_pow = EXP_TAB[w_j] >> w_n[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_idx  <= w_m[14 -: LOG_TABLE_BITS];
            r_a_sh   <= 4'd15 - w_p;
            r_a_zero <= (i_cos == '0);
            r_a_one  <= i_cos[15];
            r_b_negl <= {r_a_sh, 16'b0} - 20'(LOG_TAB[r_a_idx]);
            r_b_zero <= r_a_zero;
            r_b_one  <= r_a_one;
            r_c_t    <= w_t[35:11];
            r_c_zero <= r_b_zero;
            r_c_one  <= r_b_one;
            r_pow    <= n_pow;
        end
    end

    assign o_pow = r_pow;

endmodule

// File: rtl/phong_point_shader_unit.sv
// phong shading with one light, twelve-stage pipeline, fixed point
// depends on pps_pkg and pps_power
//
// channel | direction | handshake                   | payload
// in      | in        | i_valid / o_stall           | normal, light, view xyz, shade factor
// out     | out       | o_valid / i_stall           | out_red, out_green, out_blue
// cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one point per cycle unless the output stalls
// pipeline depth is set by the multiplier chain: dot products, R.V, log/exp power,
// split 48x16 colour product and the final shade multiply
// synchronous active-low reset clears valid bits and sets register defaults
// a stalled output freezes the whole pipeline; bubbles are not squeezed out
module phong_point_shader_unit import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_normal_x,
    input  logic signed [15:0]   i_normal_y,
    input  logic signed [15:0]   i_normal_z,
    input  logic signed [15:0]   i_light_x,
    input  logic signed [15:0]   i_light_y,
    input  logic signed [15:0]   i_light_z,
    input  logic signed [15:0]   i_view_x,
    input  logic signed [15:0]   i_view_y,
    input  logic signed [15:0]   i_view_z,
    input  logic [15:0]          i_shade_factor,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_out_red,
    output logic [15:0]          o_out_green,
    output logic [15:0]          o_out_blue,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [39:0] ONE_Q28_W = 40'sd268435456;

    logic [COLOR_W-1:0] r_albedo, r_spec, r_light;
    logic [15:0]        r_kd, r_ks, r_shine;

    logic               w_en;
    logic [NUM_STG-1:0] r_vld;

    logic signed [31:0] r_p [9];
    logic signed [33:0] r_ln, r_nv, r_lv;
    logic signed [33:0] w_ln14, w_nv14;
    logic signed [18:0] r_ln14, r_nv14;
    logic signed [33:0] r_lv3, r_lv4;
    logic signed [37:0] r_prod;
    logic signed [39:0] w_rv;
    logic [15:0]        r_c;
    logic [15:0]        r_cosd [7];
    logic [15:0]        r_shd [11];
    logic [15:0]        n_cosd, n_c;
    logic [15:0]        w_pow;

    logic [31:0]        r_ka_d [3];
    logic [31:0]        r_ka_s [3];
    logic [47:0]        r_kal_d [3];
    logic [47:0]        r_kal_s [3];
    logic [39:0]        r_pd_lo [3];
    logic [39:0]        r_pd_hi [3];
    logic [39:0]        r_ps_lo [3];
    logic [39:0]        r_ps_hi [3];
    logic [21:0]        r_d [3];
    logic [21:0]        r_s [3];
    logic [15:0]        r_out [3];

    function automatic logic [15:0] sat16(input logic [38:0] v);
        return (v > 39'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    assign w_en        = !r_vld[NUM_STG-1] || !i_stall;
    assign o_stall     = !w_en;
    assign o_valid     = r_vld[NUM_STG-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_albedo <= '0;
            r_spec   <= '0;
            r_light  <= '0;
            r_kd     <= 16'd4096;
            r_ks     <= 16'd4096;
            r_shine  <= 16'd5120;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ALBEDO:   r_albedo <= i_cfg_data;
                REG_SPECULAR: r_spec   <= i_cfg_data;
                REG_LIGHT:    r_light  <= i_cfg_data;
                REG_KD:       r_kd     <= i_cfg_data[15:0];
                REG_KS:       r_ks     <= i_cfg_data[15:0];
                REG_SHINE:    r_shine  <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_valid};
        end
    end

    // divide by 2^14 truncating toward zero
    assign w_ln14 = (r_ln + (r_ln[33] ? 34'sd16383 : 34'sd0)) >>> 14;
    assign w_nv14 = (r_nv + (r_nv[33] ? 34'sd16383 : 34'sd0)) >>> 14;
    assign w_rv   = (40'(r_prod) <<< 1) - 40'(r_lv4);

    always_comb begin
        if (r_ln <= 34'sd0) begin
            n_cosd = '0;
        end else if (r_ln >= ONE_Q28) begin
            n_cosd = 16'd32768;
        end else begin
            n_cosd = {1'b0, r_ln[27:13]};
        end
        if (w_rv <= 40'sd0) begin
            n_c = '0;
        end else if (w_rv >= ONE_Q28_W) begin
            n_c = 16'd32768;
        end else begin
            n_c = {1'b0, w_rv[27:13]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= i_light_x * i_normal_x;
            r_p[1] <= i_light_y * i_normal_y;
            r_p[2] <= i_light_z * i_normal_z;
            r_p[3] <= i_normal_x * i_view_x;
            r_p[4] <= i_normal_y * i_view_y;
            r_p[5] <= i_normal_z * i_view_z;
            r_p[6] <= i_light_x * i_view_x;
            r_p[7] <= i_light_y * i_view_y;
            r_p[8] <= i_light_z * i_view_z;
            r_ln   <= 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]);
            r_nv   <= 34'(r_p[3]) + 34'(r_p[4]) + 34'(r_p[5]);
            r_lv   <= 34'(r_p[6]) + 34'(r_p[7]) + 34'(r_p[8]);
            r_ln14 <= w_ln14[18:0];
            r_nv14 <= w_nv14[18:0];
            r_lv3  <= r_lv;
            r_prod <= r_ln14 * r_nv14;
            r_lv4  <= r_lv3;
            r_c    <= n_c;
            r_cosd[0] <= n_cosd;
            for (int k = 1; k < 7; k++) r_cosd[k] <= r_cosd[k-1];
            r_shd[0] <= i_shade_factor;
            for (int k = 1; k < 11; k++) r_shd[k] <= r_shd[k-1];
        end
    end

    pps_power u_power (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cos   (r_c),
        .i_shine (r_shine),
        .o_pow   (w_pow)
    );

    // colour path: gain*colour*light, then times cosine (diffuse) or power (specular) in two halves
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_ka_d[ch]  <= 32'(r_kd) * 32'(r_albedo[16*ch +: 16]);
                r_ka_s[ch]  <= 32'(r_ks) * 32'(r_spec[16*ch +: 16]);
                r_kal_d[ch] <= 48'(r_ka_d[ch]) * 48'(r_light[16*ch +: 16]);
                r_kal_s[ch] <= 48'(r_ka_s[ch]) * 48'(r_light[16*ch +: 16]);
                r_pd_lo[ch] <= 40'(r_kal_d[ch][23:0]) * 40'(r_cosd[6]);
                r_pd_hi[ch] <= 40'(r_kal_d[ch][47:24]) * 40'(r_cosd[6]);
                r_ps_lo[ch] <= 40'(r_kal_s[ch][23:0]) * 40'(w_pow);
                r_ps_hi[ch] <= 40'(r_kal_s[ch][47:24]) * 40'(w_pow);
                r_d[ch]     <= 22'(({r_pd_hi[ch], 24'b0} + 64'(r_pd_lo[ch])) >> 42);
                r_s[ch]     <= 22'(({r_ps_hi[ch], 24'b0} + 64'(r_ps_lo[ch])) >> 42);
                r_out[ch]   <= sat16(((39'(r_d[ch]) + 39'(r_s[ch])) * 39'(r_shd[10])) >> 15);
            end
        end
    end

    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted point missing from first stage");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_dark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[NUM_STG-2] && r_shd[10] == '0) |=>
        (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("zero shade factor gave nonzero colour");

endmodule
